>>> src/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion core.
// Used by rmq_front, rmq_fifo, rmq_back and the top level; no dependencies.
package rmq_pkg;

   localparam int unsigned FIELD_W     = 18;
   localparam int unsigned NUM_W       = 19;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;
   localparam int unsigned SAT_POS     = 131071;
   localparam int unsigned SAT_NEG_MAG = 131072;

   typedef enum logic [1:0] {
      CASE_TRACE = 2'd0,
      CASE_X     = 2'd1,
      CASE_Y     = 2'd2,
      CASE_Z     = 2'd3
   } case_type;

   typedef struct packed {
      case_type                 sel;
      logic signed [NUM_W-1:0]  n0;
      logic signed [NUM_W-1:0]  n1;
      logic signed [NUM_W-1:0]  n2;
   } cls_type;

endpackage

>>> src/rmq_front.sv
// Front end: picks the branch, forms the square root argument and numerators.
// Depends on rmq_pkg.
module rmq_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic signed [17:0]          m00,
   input  logic signed [17:0]          m01,
   input  logic signed [17:0]          m02,
   input  logic signed [17:0]          m10,
   input  logic signed [17:0]          m11,
   input  logic signed [17:0]          m12,
   input  logic signed [17:0]          m20,
   input  logic signed [17:0]          m21,
   input  logic signed [17:0]          m22,
   output rmq_pkg::cls_type            cls,
   output logic [((FRAC_BITS >= 19) ? FRAC_BITS + 1 : 20)-1:0] arg
);

   localparam int AW = (FRAC_BITS >= 19) ? FRAC_BITS + 1 : 20;
   localparam int NW = rmq_pkg::NUM_W;
   localparam logic signed [AW+1:0] ONE =
      {{(AW+1-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   logic signed [AW+1:0] e00, e11, e22, arg_s;
   logic signed [NW-1:0] f01, f02, f10, f12, f20, f21;
   logic signed [19:0]   trace;

   always_comb begin
      e00 = (AW+2)'(m00);
      e11 = (AW+2)'(m11);
      e22 = (AW+2)'(m22);
      f01 = NW'(m01);
      f02 = NW'(m02);
      f10 = NW'(m10);
      f12 = NW'(m12);
      f20 = NW'(m20);
      f21 = NW'(m21);
      trace = 20'(m00) + 20'(m11) + 20'(m22);
      if (trace > 20'sd0) begin
         cls.sel = rmq_pkg::CASE_TRACE;
         arg_s   = ONE + e00 + e11 + e22;
         cls.n0  = f21 - f12;
         cls.n1  = f02 - f20;
         cls.n2  = f10 - f01;
      end else if (m00 > m11 && m00 > m22) begin
         cls.sel = rmq_pkg::CASE_X;
         arg_s   = ONE + e00 - e11 - e22;
         cls.n0  = f21 - f12;
         cls.n1  = f01 + f10;
         cls.n2  = f02 + f20;
      end else if (m11 > m22) begin
         cls.sel = rmq_pkg::CASE_Y;
         arg_s   = ONE + e11 - e00 - e22;
         cls.n0  = f02 - f20;
         cls.n1  = f01 + f10;
         cls.n2  = f12 + f21;
      end else begin
         cls.sel = rmq_pkg::CASE_Z;
         arg_s   = ONE + e22 - e00 - e11;
         cls.n0  = f10 - f01;
         cls.n1  = f02 + f20;
         cls.n2  = f12 + f21;
      end
      arg = arg_s[AW+1] ? '0 : arg_s[AW-1:0];
   end

endmodule

>>> src/rmq_fifo.sv
// Short show-ahead queue between the front end and the arithmetic back end.
// Depends on rmq_pkg for its depth.
module rmq_fifo #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output logic [DATA_W-1:0] head
);

   localparam int PW = rmq_pkg::QUEUE_AW;

   logic [DATA_W-1:0] mem_ff [0:rmq_pkg::QUEUE_DEPTH-1];
   logic [PW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]       cnt_ff, cnt_in;
   logic              do_push, do_pop;

   always_comb begin
      full      = (cnt_ff == (PW+1)'(rmq_pkg::QUEUE_DEPTH));
      not_empty = (cnt_ff != '0);
      head      = mem_ff[rd_ff];
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      wr_in     = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in     = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in    = cnt_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(rmq_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

endmodule

>>> src/rmq_back.sv
// Back end: pipelined square root, three pipelined dividers, saturation and
// the result register. Depends on rmq_pkg.
module rmq_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_pop,
   input  rmq_pkg::cls_type            in_cls,
   input  logic [((FRAC_BITS >= 19) ? FRAC_BITS + 1 : 20)-1:0] in_arg,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [17:0]          qw,
   output logic signed [17:0]          qx,
   output logic signed [17:0]          qy,
   output logic signed [17:0]          qz,
   output rmq_pkg::case_type           case_taken
);

   localparam int AW = (FRAC_BITS >= 19) ? FRAC_BITS + 1 : 20;
   localparam int RW = ((AW + FRAC_BITS + 1) / 2) * 2;
   localparam int QW = RW / 2;
   localparam int NW = rmq_pkg::NUM_W;
   localparam int DW = FRAC_BITS + 18;

   logic adv;

   // square root pipeline
   logic                   sv_ff   [0:QW];
   logic [RW-1:0]          srad_ff [0:QW];
   logic [QW:0]            srem_ff [0:QW];
   logic [QW-1:0]          sroot_ff[0:QW];
   rmq_pkg::cls_type       scls_ff [0:QW];

   // divider pipeline
   logic                   dv_ff   [0:DW];
   rmq_pkg::case_type      dsel_ff [0:DW];
   logic [QW-1:0]          dr_ff   [0:DW];
   logic                   dz_ff   [0:DW];
   logic [QW-1:0]          dpiv_ff [0:DW];
   logic [2:0]             dneg_ff [0:DW];
   logic [DW-1:0]          dd_ff   [0:DW][3];
   logic [QW-1:0]          drem_ff [0:DW][3];
   logic [DW-1:0]          dq_ff   [0:DW][3];

   logic                   out_v_ff;
   logic signed [17:0]     ow_ff, ox_ff, oy_ff, oz_ff;
   rmq_pkg::case_type      osel_ff;

   assign adv    = !out_v_ff || rsp_ready;
   assign in_pop = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         srad_ff[0]  <= RW'(in_arg) << FRAC_BITS;
         srem_ff[0]  <= '0;
         sroot_ff[0] <= '0;
         scls_ff[0]  <= in_cls;
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_sqrt
      logic [QW+2:0] trial, diff;
      always_comb begin
         trial = {srem_ff[j-1], srad_ff[j-1][RW-1:RW-2]};
         diff  = trial - {1'b0, sroot_ff[j-1], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j] <= 1'b0;
         end else if (adv) begin
            sv_ff[j] <= sv_ff[j-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            srad_ff[j]  <= srad_ff[j-1] << 2;
            srem_ff[j]  <= diff[QW+2] ? trial[QW:0] : diff[QW:0];
            sroot_ff[j] <= {sroot_ff[j-1][QW-2:0], !diff[QW+2]};
            scls_ff[j]  <= scls_ff[j-1];
         end
      end
   end

   logic signed [NW-1:0] nsrc [3];
   logic [NW-1:0]        nmag [3];
   always_comb begin
      nsrc[0] = scls_ff[QW].n0;
      nsrc[1] = scls_ff[QW].n1;
      nsrc[2] = scls_ff[QW].n2;
      for (int k = 0; k < 3; k++) begin
         nmag[k] = nsrc[k][NW-1] ? NW'(-nsrc[k]) : NW'(nsrc[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= sv_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dsel_ff[0] <= scls_ff[QW].sel;
         dr_ff[0]   <= sroot_ff[QW];
         dz_ff[0]   <= (sroot_ff[QW] == '0);
         dpiv_ff[0] <= sroot_ff[QW] >> 1;
         for (int k = 0; k < 3; k++) begin
            dneg_ff[0][k] <= nsrc[k][NW-1];
            dd_ff[0][k]   <= DW'(nmag[k]) << (FRAC_BITS - 1);
            drem_ff[0][k] <= '0;
            dq_ff[0][k]   <= '0;
         end
      end
   end

   for (genvar j = 1; j <= DW; j++) begin : g_div
      logic [QW:0] trial [3];
      logic        ge    [3];
      always_comb begin
         for (int k = 0; k < 3; k++) begin
            trial[k] = {drem_ff[j-1][k], dd_ff[j-1][k][DW-1]};
            ge[k]    = (trial[k] >= {1'b0, dr_ff[j-1]});
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_ff[j] <= dv_ff[j-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dsel_ff[j] <= dsel_ff[j-1];
            dr_ff[j]   <= dr_ff[j-1];
            dz_ff[j]   <= dz_ff[j-1];
            dpiv_ff[j] <= dpiv_ff[j-1];
            dneg_ff[j] <= dneg_ff[j-1];
            for (int k = 0; k < 3; k++) begin
               dd_ff[j][k]   <= dd_ff[j-1][k] << 1;
               drem_ff[j][k] <= ge[k] ? QW'(trial[k] - {1'b0, dr_ff[j-1]})
                                      : trial[k][QW-1:0];
               dq_ff[j][k]   <= {dq_ff[j-1][k][DW-2:0], ge[k]};
            end
         end
      end
   end

   logic signed [17:0] sat [3];
   logic signed [17:0] piv_sat;
   logic signed [17:0] ow_in, ox_in, oy_in, oz_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dz_ff[DW]) begin
            sat[k] = '0;
         end else if (dneg_ff[DW][k]) begin
            sat[k] = (dq_ff[DW][k] > DW'(rmq_pkg::SAT_NEG_MAG)) ? 18'sh20000
                                                              : -18'(dq_ff[DW][k]);
         end else begin
            sat[k] = (dq_ff[DW][k] > DW'(rmq_pkg::SAT_POS)) ? 18'sh1FFFF
                                                          : 18'(dq_ff[DW][k]);
         end
      end
      piv_sat = (dpiv_ff[DW] > QW'(rmq_pkg::SAT_POS)) ? 18'sh1FFFF : 18'(dpiv_ff[DW]);
      case (dsel_ff[DW])
         rmq_pkg::CASE_TRACE: begin
            ow_in = piv_sat; ox_in = sat[0]; oy_in = sat[1]; oz_in = sat[2];
         end
         rmq_pkg::CASE_X: begin
            ow_in = sat[0]; ox_in = piv_sat; oy_in = sat[1]; oz_in = sat[2];
         end
         rmq_pkg::CASE_Y: begin
            ow_in = sat[0]; ox_in = sat[1]; oy_in = piv_sat; oz_in = sat[2];
         end
         default: begin
            ow_in = sat[0]; ox_in = sat[1]; oy_in = sat[2]; oz_in = piv_sat;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_ff[DW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ow_ff   <= ow_in;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
         oz_ff   <= oz_in;
         osel_ff <= dsel_ff[DW];
      end
   end

   assign rsp_valid  = out_v_ff;
   assign qw         = ow_ff;
   assign qx         = ox_ff;
   assign qy         = oy_ff;
   assign qz         = oz_ff;
   assign case_taken = osel_ff;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !out_v_ff)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv_ff[DW]) && $stable(sv_ff[QW]) && $stable(out_v_ff))
      else $error("pipeline moved while stalled");

   a_trace_pivot: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && osel_ff == rmq_pkg::CASE_TRACE |-> !ow_ff[17])
      else $error("negative scalar part in trace branch");

endmodule

>>> src/rotation_matrix_to_quaternion_core.sv
// Top level of the rotation matrix to quaternion core (Shepperd's method).
// Depends on rmq_pkg, rmq_front, rmq_fifo and rmq_back.
//
// Usage:
//   req channel: one 3x3 matrix per transfer, nine signed elements in tdata.
//   rsp channel: one quaternion per transfer in tdata, branch in tuser.
//   The square root resolves one root bit per stage over a QW-bit root,
//     QW = ceil((A + FRAC_BITS) / 2), A = max(FRAC_BITS + 1, 20), and each
//     divider resolves one quotient bit per stage over a DW-bit quotient,
//     DW = FRAC_BITS + 18.
//   Throughput: one transfer per cycle while rsp_tready is high; a
//     held result stalls both pipelines.
//   Reset clears the queue and all stage valid bits; no result follows.
//   When rsp_tready is low while a result is valid, the result register and both pipelines hold;
//   the four-entry queue keeps taking requests until it is full, then
//   req_tready drops.
module rotation_matrix_to_quaternion_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 (18 bits each), 6 zero bits
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // qw, qx, qy, qz (18 bits each)
   output logic [71:0]  rsp_tdata,
   // case_taken (2 bits), 6 zero bits
   output logic [7:0]   rsp_tuser
);

   localparam int AW = (FRAC_BITS >= 19) ? FRAC_BITS + 1 : 20;
   localparam int CW = $bits(rmq_pkg::cls_type);
   localparam int QDW = AW + CW;

   rmq_pkg::cls_type  f_cls, b_cls;
   logic [AW-1:0]     f_arg, b_arg;
   logic [QDW-1:0]    q_head;
   logic              q_full, q_ne, b_pop;
   logic signed [17:0] qw, qx, qy, qz;
   rmq_pkg::case_type case_taken;

   rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .m00 (req_tdata[17:0]),
      .m01 (req_tdata[35:18]),
      .m02 (req_tdata[53:36]),
      .m10 (req_tdata[71:54]),
      .m11 (req_tdata[89:72]),
      .m12 (req_tdata[107:90]),
      .m20 (req_tdata[125:108]),
      .m21 (req_tdata[143:126]),
      .m22 (req_tdata[161:144]),
      .cls (f_cls),
      .arg (f_arg)
   );

   rmq_fifo #(.DATA_W(QDW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data ({f_arg, f_cls}),
      .full      (q_full),
      .pop       (b_pop),
      .not_empty (q_ne),
      .head      (q_head)
   );

   assign req_tready = !q_full;
   assign b_cls      = q_head[CW-1:0];
   assign b_arg      = q_head[QDW-1:CW];

   rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_ne),
      .in_pop     (b_pop),
      .in_cls     (b_cls),
      .in_arg     (b_arg),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .qw         (qw),
      .qx         (qx),
      .qy         (qy),
      .qz         (qz),
      .case_taken (case_taken)
   );

   assign rsp_tdata = {qz, qy, qx, qw};
   assign rsp_tuser = {6'b0, case_taken};

endmodule
